// ===== hdl/tcw_pkg.sv =====
// Shared codes and types for the text console writer.
package tcw_pkg;

    typedef logic [1:0] mode_t;
    typedef logic [1:0] kind_t;

    localparam mode_t MODE_PUT   = 2'd0;
    localparam mode_t MODE_SET   = 2'd1;
    localparam mode_t MODE_CLEAR = 2'd2;
    localparam mode_t MODE_READ  = 2'd3;

    localparam kind_t KIND_ECHO   = 2'd0;
    localparam kind_t KIND_CURSOR = 2'd1;
    localparam kind_t KIND_CELL   = 2'd2;

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] ATTR_RESET = 8'h07;

endpackage

// ===== hdl/tcw_cell_ram.sv =====
// Cell store: one write port, one registered read port.
module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [15:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/text_console_writer_top.sv =====
// Text console writer: cursor, cell store, put-char, set-cursor, clear and read-cell.
//
// Character-cell console of COLUMNS x ROWS cells, each cell holding
// attribute<<8 | character in a single-port-write, registered-read memory.
// One request is handled at a time. A line break adds CR and LF echoes,
// and each result waits while the output register is stalled. A scroll walks
// the whole store once, copying each cell up one row and zeroing the bottom
// row, before the character that causes it is written. A clear zeroes every
// cell, homes the cursor and reports it. After reset the same zeroing pass
// runs with in_stall high; cfg writes are taken at any time. The output
// register lets the next request be accepted while a result waits.
module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_code,
    input  logic [6:0]  column,
    input  logic [4:0]  row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [15:0] value,
    output logic        last
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(COLUMNS + 1);
    localparam int RW         = $clog2(ROWS + 1);

    localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
    localparam logic [AW-1:0] COPY_LIMIT = AW'(CELL_COUNT - COLUMNS);
    localparam logic [AW-1:0] LAST_IDX   = AW'(CELL_COUNT - 1);
    localparam logic [CW-1:0] COL_MAX    = CW'(COLUMNS - 1);
    localparam logic [CW-1:0] COL_END    = CW'(COLUMNS);
    localparam logic [RW-1:0] ROW_MAX    = RW'(ROWS - 1);
    localparam logic [RW-1:0] ROW_END    = RW'(ROWS);

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_EXEC       = 4'd1;
    localparam logic [3:0] ST_CR         = 4'd2;
    localparam logic [3:0] ST_LF         = 4'd3;
    localparam logic [3:0] ST_PRINT      = 4'd4;
    localparam logic [3:0] ST_SCROLL     = 4'd5;
    localparam logic [3:0] ST_SCROLL_END = 4'd6;
    localparam logic [3:0] ST_CLEAR      = 4'd7;
    localparam logic [3:0] ST_CLEAR_END  = 4'd8;
    localparam logic [3:0] ST_CLEAR_OUT  = 4'd9;
    localparam logic [3:0] ST_READ       = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic          clear_emit_reg, clear_emit_next;
    logic [7:0]    attr_reg;

    tcw_pkg::mode_t mode_reg;
    logic [7:0]    char_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    logic          pipe_valid_reg, pipe_valid_next;
    logic [AW-1:0] pipe_waddr_reg, pipe_waddr_next;
    logic          pipe_zero_reg, pipe_zero_next;

    logic          out_valid_reg;
    tcw_pkg::kind_t kind_reg;
    logic [15:0]   value_reg;
    logic          last_reg;

    logic          emit;
    tcw_pkg::kind_t emit_kind;
    logic [15:0]   emit_value;
    logic          emit_last;
    logic          out_ok;
    logic          accept;
    logic          print_we;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;
    logic [AW-1:0] item_addr;
    logic [AW-1:0] cur_addr;
    logic [CW-1:0] col_clamped;
    logic [RW-1:0] row_clamped;

    assign out_ok    = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign item_addr = AW'(row_reg) * COLS_A + AW'(col_reg);
    assign cur_addr  = AW'(cur_row_reg) * COLS_A + AW'(cur_col_reg);

    assign col_clamped = (32'(column) > COLUMNS - 1) ? COL_MAX : CW'(column);
    assign row_clamped = (32'(row) > ROWS - 1) ? ROW_MAX : RW'(row);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        clear_emit_next = clear_emit_reg;
        pipe_valid_next = 1'b0;
        pipe_waddr_next = idx_reg;
        pipe_zero_next  = 1'b1;
        emit            = 1'b0;
        emit_kind       = tcw_pkg::KIND_ECHO;
        emit_value      = 16'd0;
        emit_last       = 1'b0;
        print_we        = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = item_addr;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (mode_reg)
                    tcw_pkg::MODE_PUT:
                    begin
                        if (cur_col_reg >= COL_END || char_reg == tcw_pkg::CHAR_LF)
                        begin
                            // bump saturates one past the bottom row
                            if (cur_row_reg < ROW_END)
                            begin
                                cur_row_next = cur_row_reg + RW'(1);
                            end
                            cur_col_next = '0;
                            state_next   = ST_CR;
                        end
                        else
                        begin
                            state_next = ST_PRINT;
                        end
                    end
                    tcw_pkg::MODE_SET:
                    begin
                        if (out_ok)
                        begin
                            emit         = 1'b1;
                            emit_kind    = tcw_pkg::KIND_CURSOR;
                            emit_value   = 16'(item_addr);
                            emit_last    = 1'b1;
                            cur_col_next = col_reg;
                            cur_row_next = row_reg;
                            state_next   = ST_IDLE;
                        end
                    end
                    tcw_pkg::MODE_CLEAR:
                    begin
                        idx_next        = '0;
                        clear_emit_next = 1'b1;
                        state_next      = ST_CLEAR;
                    end
                    tcw_pkg::MODE_READ:
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = item_addr;
                        state_next = ST_READ;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_CR:
            begin
                if (out_ok)
                begin
                    emit       = 1'b1;
                    emit_value = 16'(tcw_pkg::CHAR_CR);
                    state_next = ST_LF;
                end
            end
            ST_LF:
            begin
                if (out_ok)
                begin
                    emit       = 1'b1;
                    emit_value = 16'(tcw_pkg::CHAR_LF);
                    emit_last  = (char_reg == tcw_pkg::CHAR_LF);
                    state_next = (char_reg == tcw_pkg::CHAR_LF) ? ST_IDLE : ST_PRINT;
                end
            end
            ST_PRINT:
            begin
                if (cur_row_reg > ROW_MAX)
                begin
                    idx_next   = '0;
                    state_next = ST_SCROLL;
                end
                else if (out_ok)
                begin
                    print_we     = 1'b1;
                    emit         = 1'b1;
                    emit_value   = 16'(char_reg);
                    emit_last    = 1'b1;
                    cur_col_next = cur_col_reg + CW'(1);
                    state_next   = ST_IDLE;
                end
            end
            ST_SCROLL:
            begin
                // read one row down now, write back on the following cycle
                pipe_valid_next = 1'b1;
                pipe_waddr_next = idx_reg;
                pipe_zero_next  = (idx_reg >= COPY_LIMIT);
                if (idx_reg < COPY_LIMIT)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + COLS_A;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_SCROLL_END;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_SCROLL_END:
            begin
                cur_row_next = ROW_MAX;
                state_next   = ST_PRINT;
            end
            ST_CLEAR:
            begin
                pipe_valid_next = 1'b1;
                pipe_waddr_next = idx_reg;
                pipe_zero_next  = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_CLEAR_END;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_CLEAR_END:
            begin
                cur_col_next = '0;
                cur_row_next = '0;
                state_next   = clear_emit_reg ? ST_CLEAR_OUT : ST_IDLE;
            end
            ST_CLEAR_OUT:
            begin
                if (out_ok)
                begin
                    emit            = 1'b1;
                    emit_kind       = tcw_pkg::KIND_CURSOR;
                    emit_value      = 16'd0;
                    emit_last       = 1'b1;
                    clear_emit_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (out_ok)
                begin
                    emit       = 1'b1;
                    emit_kind  = tcw_pkg::KIND_CELL;
                    emit_value = ram_rdata;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_we    = pipe_valid_reg || print_we;
    assign ram_waddr = pipe_valid_reg ? pipe_waddr_reg : cur_addr;
    assign ram_wdata = pipe_valid_reg ? (pipe_zero_reg ? 16'd0 : ram_rdata)
                                      : {attr_reg, char_reg};

    tcw_cell_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            clear_emit_reg <= 1'b0;
            pipe_valid_reg <= 1'b0;
            attr_reg       <= tcw_pkg::ATTR_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            clear_emit_reg <= clear_emit_next;
            pipe_valid_reg <= pipe_valid_next;
            if (cfg_write_en)
            begin
                attr_reg <= cfg_write_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_waddr_reg <= pipe_waddr_next;
        pipe_zero_reg  <= pipe_zero_next;
        if (accept)
        begin
            mode_reg <= mode;
            char_reg <= char_code;
            col_reg  <= col_clamped;
            row_reg  <= row_clamped;
        end
        if (emit)
        begin
            kind_reg  <= emit_kind;
            value_reg <= emit_value;
            last_reg  <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign last      = last_reg;

endmodule

// ===== hdl/tcw_checker.sv =====
// Port-level checks for the text console writer, bound to the top level.
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [15:0] value,
    input logic        last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(value)
            && $stable(last))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind == tcw_pkg::KIND_ECHO || kind == tcw_pkg::KIND_CURSOR
            || kind == tcw_pkg::KIND_CELL)
    else $error("result kind out of range");

    // cursor and cell results stand alone
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != tcw_pkg::KIND_ECHO |-> last)
    else $error("single result not marked last");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == tcw_pkg::KIND_CURSOR |-> 32'(value) < COLUMNS * ROWS)
    else $error("cursor position beyond screen");

    // a line-break CR is followed directly by LF
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && kind == tcw_pkg::KIND_ECHO
            && value == 16'(tcw_pkg::CHAR_CR) && !last
            |=> out_valid && kind == tcw_pkg::KIND_ECHO
            && value == 16'(tcw_pkg::CHAR_LF))
    else $error("line break CR not followed by LF");

endmodule

bind text_console_writer_top tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .value     (value),
    .last      (last)
);
